### hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table: request and response
// words, status codes, cell operations, the per-cell compare flags and the controller states.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int POS_W     = 9;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t              req_type;
        logic [KEY_W-1:0]       key;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   allow_dup;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic                   found;
        logic [POS_W-1:0]       position;
        logic [PAYLOAD_W-1:0]   payload_out;
        logic [POS_W-1:0]       entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_CMP  = 2'd1,
        CELL_INS  = 2'd2,
        CELL_REM  = 2'd3
    } cell_op_t;

    // ge: entry key >= request key or slot empty
    // gt: entry key >  request key or slot empty
    // eq: slot occupied and entry key == request key
    typedef struct packed {
        logic ge;
        logic gt;
        logic eq;
    } cell_flags_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SEL  = 2'd1,
        S_UPD  = 2'd2
    } state_t;

endpackage

### hw/rtl/sorted_key_table.sv
// Each request passes the cell compare, the bound select over the chain, then
// the cell shift and response load; a new request is taken only in idle, once
// the previous one is through its update, which waits while a response is held.
// A waiting response does not block the next request's compare and select.
// Reset: entry count goes to zero and the table is empty; slot contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted key/payload table built as a chain of compare-and-shift cells with
// lookup, insert, remove and clear requests.
// ----------------------------------------------------------------------------
module sorted_key_table #(
    parameter int CAPACITY     = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  skt_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output skt_pkg::rsp_t  rsp
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    req_t                req_reg;

    cell_op_t                cell_op;
    logic                    sel_en;
    logic [KEY_BITS-1:0]     cell_key;
    logic [PAYLOAD_BITS-1:0] cell_payload;

    logic [KEY_BITS-1:0]     key_w     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] payload_w [CAPACITY];
    cell_flags_t             flags_w   [CAPACITY];

    logic [CNT_W-1:0]        sel_lo;
    logic [CNT_W-1:0]        sel_hi;
    logic                    sel_found;
    logic [PAYLOAD_BITS-1:0] sel_pay;
    logic                    full;

    // compare uses the incoming key on the accept edge, later steps the held one
    assign cell_key     = (state_reg == S_IDLE) ? KEY_BITS'(req.key) : KEY_BITS'(req_reg.key);
    assign cell_payload = PAYLOAD_BITS'(req_reg.payload);
    assign full         = (count_reg == CNT_W'(CAPACITY));

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [KEY_BITS-1:0]     prev_k;
        logic [PAYLOAD_BITS-1:0] prev_p;
        cell_flags_t             prev_f;
        logic [KEY_BITS-1:0]     next_k;
        logic [PAYLOAD_BITS-1:0] next_p;

        if (g == 0)
        begin : g_first
            assign prev_k = key_w[g];
            assign prev_p = payload_w[g];
            assign prev_f = '0;
        end
        else
        begin : g_mid_lo
            assign prev_k = key_w[g-1];
            assign prev_p = payload_w[g-1];
            assign prev_f = flags_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_k = key_w[g];
            assign next_p = payload_w[g];
        end
        else
        begin : g_mid_hi
            assign next_k = key_w[g+1];
            assign next_p = payload_w[g+1];
        end

        skt_cell #(
            .INDEX        (g),
            .CNT_W        (CNT_W),
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk          (clk),
            .op           (cell_op),
            .count        (count_reg),
            .req_key      (cell_key),
            .req_payload  (cell_payload),
            .prev_key     (prev_k),
            .prev_payload (prev_p),
            .prev_flags   (prev_f),
            .next_key     (next_k),
            .next_payload (next_p),
            .key_q        (key_w[g]),
            .payload_q    (payload_w[g]),
            .flags        (flags_w[g])
        );
    end

    skt_select #(
        .CAPACITY     (CAPACITY),
        .CNT_W        (CNT_W),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_select (
        .clk     (clk),
        .en      (sel_en),
        .flags   (flags_w),
        .payload (payload_w),
        .lo      (sel_lo),
        .hi      (sel_hi),
        .found   (sel_found),
        .pay     (sel_pay)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cell_op        = CELL_HOLD;
        sel_en         = 1'b0;
        req_ready      = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cell_op    = CELL_CMP;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                sel_en     = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // hold until the response slot is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                    rsp_next.status      = ST_DONE;
                    rsp_next.found       = sel_found;
                    rsp_next.payload_out = PAYLOAD_W'(sel_pay);
                    rsp_next.position    = POS_W'(sel_lo);
                    case (req_reg.req_type)
                        REQ_LOOKUP:
                        begin
                            if (!sel_found)
                            begin
                                rsp_next.status   = ST_MISS;
                                rsp_next.position = POS_W'(count_reg);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (sel_found)
                            begin
                                cell_op    = CELL_REM;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                rsp_next.status   = ST_MISS;
                                rsp_next.position = POS_W'(count_reg);
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (sel_found && !req_reg.allow_dup)
                            begin
                                rsp_next.status = ST_DUP;
                            end
                            else if (full)
                            begin
                                rsp_next.status   = ST_FULL;
                                rsp_next.position = POS_W'(sel_hi);
                            end
                            else
                            begin
                                rsp_next.position = POS_W'(sel_hi);
                                cell_op           = CELL_INS;
                                count_next        = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            rsp_next.found       = 1'b0;
                            rsp_next.payload_out = '0;
                            rsp_next.position    = '0;
                            count_next           = '0;
                        end
                    endcase
                    rsp_next.entry_count = POS_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key and payload, compares against the request key
// and shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module skt_cell #(
    parameter int INDEX        = 0,
    parameter int CNT_W        = 9,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                     clk,
    input  skt_pkg::cell_op_t        op,
    input  logic [CNT_W-1:0]         count,
    input  logic [KEY_BITS-1:0]      req_key,
    input  logic [PAYLOAD_BITS-1:0]  req_payload,
    input  logic [KEY_BITS-1:0]      prev_key,
    input  logic [PAYLOAD_BITS-1:0]  prev_payload,
    input  skt_pkg::cell_flags_t     prev_flags,
    input  logic [KEY_BITS-1:0]      next_key,
    input  logic [PAYLOAD_BITS-1:0]  next_payload,
    output logic [KEY_BITS-1:0]      key_q,
    output logic [PAYLOAD_BITS-1:0]  payload_q,
    output skt_pkg::cell_flags_t     flags
);
    import skt_pkg::*;

    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    cell_flags_t             flags_reg;
    logic                    in_range;

    assign in_range = count > CNT_W'(INDEX);

    always_ff @(posedge clk)
    begin
        case (op)
            CELL_CMP:
            begin
                flags_reg.ge <= !in_range || (key_reg >= req_key);
                flags_reg.gt <= !in_range || (key_reg > req_key);
                flags_reg.eq <= in_range && (key_reg == req_key);
            end
            CELL_INS:
            begin
                // slots at or past the insertion point move up by one
                if (flags_reg.gt)
                begin
                    if (prev_flags.gt)
                    begin
                        key_reg     <= prev_key;
                        payload_reg <= prev_payload;
                    end
                    else
                    begin
                        key_reg     <= req_key;
                        payload_reg <= req_payload;
                    end
                end
            end
            CELL_REM:
            begin
                // slots at or past the removed entry pull from above
                if (flags_reg.ge)
                begin
                    key_reg     <= next_key;
                    payload_reg <= next_payload;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign key_q     = key_reg;
    assign payload_q = payload_reg;
    assign flags     = flags_reg;

endmodule

### hw/rtl/skt_select.sv
// ----------------------------------------------------------------------------
// skt_select
// Finds the lower and upper bound edges in the cell flags, encodes their
// positions and picks the payload of the first matching entry.
// ----------------------------------------------------------------------------
module skt_select #(
    parameter int CAPACITY     = 256,
    parameter int CNT_W        = 9,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  skt_pkg::cell_flags_t     flags [CAPACITY],
    input  logic [PAYLOAD_BITS-1:0]  payload [CAPACITY],
    output logic [CNT_W-1:0]         lo,
    output logic [CNT_W-1:0]         hi,
    output logic                     found,
    output logic [PAYLOAD_BITS-1:0]  pay
);
    import skt_pkg::*;

    logic [CAPACITY-1:0]     lo_edge;
    logic [CAPACITY-1:0]     hi_edge;
    logic [CAPACITY-1:0]     hit;
    logic [CNT_W-1:0]        lo_enc;
    logic [CNT_W-1:0]        hi_enc;
    logic [PAYLOAD_BITS-1:0] pay_sel;

    logic [CNT_W-1:0]        lo_reg;
    logic [CNT_W-1:0]        hi_reg;
    logic                    found_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    function automatic logic [CAPACITY-1:0] flags_eq_vec();
        logic [CAPACITY-1:0] v;
        for (int i = 0; i < CAPACITY; i++)
            v[i] = flags[i].eq;
        return v;
    endfunction

    always_comb
    begin
        lo_edge[0] = flags[0].ge;
        hi_edge[0] = flags[0].gt;
        for (int i = 1; i < CAPACITY; i++)
        begin
            lo_edge[i] = flags[i].ge & ~flags[i-1].ge;
            hi_edge[i] = flags[i].gt & ~flags[i-1].gt;
        end
        hit     = lo_edge & {flags_eq_vec()};
        lo_enc  = '0;
        hi_enc  = '0;
        pay_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            lo_enc  = lo_enc | (lo_edge[i] ? CNT_W'(i) : '0);
            hi_enc  = hi_enc | (hi_edge[i] ? CNT_W'(i) : '0);
            pay_sel = pay_sel | ({PAYLOAD_BITS{hit[i]}} & payload[i]);
        end
        // no edge means every slot is full and below the key (at or below it for the upper bound)
        if (lo_edge == '0)
            lo_enc = CNT_W'(CAPACITY);
        if (hi_edge == '0)
            hi_enc = CNT_W'(CAPACITY);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg    <= lo_enc;
            hi_reg    <= hi_enc;
            found_reg <= |hit;
            pay_reg   <= pay_sel;
        end
    end

    assign lo    = lo_reg;
    assign hi    = hi_reg;
    assign found = found_reg;
    assign pay   = pay_reg;

endmodule
